[src/crb_pkg.sv]
// Package for the capture ring buffer: sizes, request codes and the payload
// structs of the request and result channels.
// No dependencies.
package crb_pkg;

	// Store geometry and sample width.
	localparam int unsigned STORE_DEPTH = 1024;
	localparam int unsigned SAMPLE_BITS = 32;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned IDX_W       = $clog2(STORE_DEPTH + 1);

	// Fixed field widths.
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned POP_BITS   = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH   = 1'b1;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_SAMPLE = 2'd1,
		REQ_POP    = 2'd2,
		REQ_STOP   = 2'd3
	} req_type_t;

	// One request transaction.
	typedef struct packed {
		req_type_t   req_type;
		logic [31:0] sample_value;
		logic        sample_error;
	} req_item_t;

	// One result transaction.
	typedef struct packed {
		logic [POP_BITS-1:0]   pop_data;
		logic                  pop_valid;
		logic [CFG_DATA_W-1:0] avail_count;
		logic                  session_open;
		logic                  capturing;
		logic                  overflow_flag;
		logic                  too_fast_flag;
		logic                  req_error;
	} res_item_t;

endpackage

[src/crb_req_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on crb_pkg.
interface crb_req_if;
	import crb_pkg::*;

	logic      valid;
	logic      ready;
	req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface crb_res_if;
	import crb_pkg::*;

	logic      valid;
	logic      ready;
	res_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

[src/crb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module crb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[src/capture_ring_buffer.sv]
// Capture ring buffer: a request register, one pass of index and flag logic,
// and a result register, with the sample store in a RAM of registered read.
// A request passes through the request register and then the result register;
// a result channel that does not take results holds both.
// Throughput: one request per cycle while results are taken; the pop read and
// the index update fit in that one pass. Reset clears indices, flags and
// configuration (one-shot mode, length 1024); the sample store is not cleared.
module capture_ring_buffer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [crb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crb_pkg::CFG_DATA_W-1:0]    cfg_data,
	crb_req_if.sink                           req_ch,
	crb_res_if.source                         res_ch
);
	import crb_pkg::*;

	typedef struct packed {
		logic                  pop_valid;
		logic [CFG_DATA_W-1:0] avail_count;
		logic                  session_open;
		logic                  capturing;
		logic                  overflow_flag;
		logic                  too_fast_flag;
		logic                  req_error;
	} status_t;

	// Configuration registers.
	logic                  cfg_mode_q;
	logic [CFG_DATA_W-1:0] cfg_len_q;

	// Request stage.
	logic      valid_s1;
	req_item_t item_s1;
	logic      advance;

	// Session state.
	logic [IDX_W-1:0] wr_q, rd_q, len_q;
	logic             cont_q, open_q, armed_q, disc_q, ovf_q, err_q;

	// Next-state values.
	logic [IDX_W-1:0] wr_n, rd_n, len_n, wr_p1, rd_p1, eff_len;
	logic             cont_n, open_n, armed_n, disc_n, ovf_n, err_n;
	logic             rerr, pvalid, ram_we, ram_re;
	logic [IDX_W-1:0] avail_cur, avail_n;

	// Result stage.
	logic                   res_valid_q;
	status_t                res_q;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	// Entries stored and not yet popped.
	function automatic logic [IDX_W-1:0] avail_of(
		input logic             open,
		input logic             cont,
		input logic [IDX_W-1:0] wr,
		input logic [IDX_W-1:0] rd,
		input logic [IDX_W-1:0] len
	);
		logic [IDX_W-1:0] r;
		r = '0;
		if (open) begin
			if (cont && rd > wr) begin
				r = len - rd + wr;
			end else if (wr >= rd) begin
				r = wr - rd;
			end
		end
		return r;
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode_q <= 1'b0;
			cfg_len_q  <= CFG_DATA_W'(STORE_DEPTH);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CONTINUOUS_MODE: cfg_mode_q <= cfg_data[0];
				CFG_BUFFER_LENGTH:   cfg_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the request stage moves on when the result register is free or is being taken.
	assign advance      = valid_s1 && (!res_valid_q || res_ch.ready);
	assign req_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ch.ready) begin
			valid_s1 <= req_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			item_s1 <= req_ch.item;
		end
	end

	// Length in use: zero acts as one, anything past the store saturates.
	always_comb begin
		if (cfg_len_q == '0) begin
			eff_len = IDX_W'(1);
		end else if (32'(cfg_len_q) > STORE_DEPTH) begin
			eff_len = IDX_W'(STORE_DEPTH);
		end else begin
			eff_len = IDX_W'(cfg_len_q);
		end
	end

	assign wr_p1     = wr_q + IDX_W'(1);
	assign rd_p1     = rd_q + IDX_W'(1);
	assign avail_cur = avail_of(open_q, cont_q, wr_q, rd_q, len_q);

	// Request handling for the transaction in the request stage.
	always_comb begin
		wr_n    = wr_q;
		rd_n    = rd_q;
		len_n   = len_q;
		cont_n  = cont_q;
		open_n  = open_q;
		armed_n = armed_q;
		disc_n  = disc_q;
		ovf_n   = ovf_q;
		err_n   = err_q;
		rerr    = 1'b0;
		pvalid  = 1'b0;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		case (item_s1.req_type)
			REQ_START: begin
				if (open_q) begin
					rerr = 1'b1;
				end else begin
					wr_n    = '0;
					rd_n    = '0;
					open_n  = 1'b1;
					armed_n = 1'b1;
					disc_n  = 1'b1;
					ovf_n   = 1'b0;
					err_n   = 1'b0;
					cont_n  = cfg_mode_q;
					len_n   = eff_len;
				end
			end
			REQ_SAMPLE: begin
				if (armed_q) begin
					if (item_s1.sample_error) begin
						armed_n = 1'b0;
						err_n   = 1'b1;
					end else if (disc_q) begin
						disc_n = 1'b0;
					end else if (cont_q && ((wr_p1 == len_q && rd_q == '0) || wr_p1 == rd_q)) begin
						armed_n = 1'b0;
						ovf_n   = 1'b1;
					end else begin
						ram_we = 1'b1;
						wr_n   = wr_p1;
						if (wr_p1 >= len_q) begin
							if (cont_q) begin
								wr_n = '0;
							end else begin
								armed_n = 1'b0;
							end
						end
					end
				end
			end
			REQ_POP: begin
				if (avail_cur == '0) begin
					rerr = 1'b1;
				end else begin
					pvalid = 1'b1;
					ram_re = 1'b1;
					rd_n   = (cont_q && rd_p1 >= len_q) ? '0 : rd_p1;
				end
			end
			REQ_STOP: begin
				if (open_q) begin
					armed_n = 1'b0;
					open_n  = 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign avail_n = avail_of(open_n, cont_n, wr_n, rd_n, len_n);

	// Session state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			len_q   <= IDX_W'(1);
			cont_q  <= 1'b0;
			open_q  <= 1'b0;
			armed_q <= 1'b0;
			disc_q  <= 1'b0;
			ovf_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (advance) begin
			wr_q    <= wr_n;
			rd_q    <= rd_n;
			len_q   <= len_n;
			cont_q  <= cont_n;
			open_q  <= open_n;
			armed_q <= armed_n;
			disc_q  <= disc_n;
			ovf_q   <= ovf_n;
			err_q   <= err_n;
		end
	end

	// Sample store; pop data arrives with the result register.
	crb_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (advance && ram_we),
		.waddr(wr_q[ADDR_W-1:0]),
		.wdata(SAMPLE_BITS'(item_s1.sample_value)),
		.re   (advance && ram_re),
		.raddr(rd_q[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.pop_valid     <= pvalid;
			res_q.avail_count   <= CFG_DATA_W'(avail_n);
			res_q.session_open  <= open_n;
			res_q.capturing     <= armed_n;
			res_q.overflow_flag <= ovf_n;
			res_q.too_fast_flag <= err_n;
			res_q.req_error     <= rerr;
		end
	end

	assign res_ch.valid = res_valid_q;
	assign res_ch.item  = '{
		pop_data:      res_q.pop_valid ? POP_BITS'(ram_rdata) : '0,
		pop_valid:     res_q.pop_valid,
		avail_count:   res_q.avail_count,
		session_open:  res_q.session_open,
		capturing:     res_q.capturing,
		overflow_flag: res_q.overflow_flag,
		too_fast_flag: res_q.too_fast_flag,
		req_error:     res_q.req_error
	};

	// Capture is only armed inside an open session.
	a_armed_open: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> open_q)
		else $error("capture armed without an open session");

	// The write index never runs past the length in use.
	a_wr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (wr_q <= len_q))
		else $error("write index beyond buffer length");

	// A closed session reports no available entries.
	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.session_open) |-> (res_q.avail_count == '0))
		else $error("entries reported with no session open");

	// A successful pop shows up as a valid pop in the next result.
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pvalid) |=> (res_valid_q && res_q.pop_valid && !res_q.req_error))
		else $error("pop result lost");
endmodule
